// ===== hdl/tie_change_category_histogram_defines.svh =====
// Assertion macros used by the tie change histogram checker.
`ifndef TIE_CHANGE_CATEGORY_HISTOGRAM_DEFINES_SVH
`define TIE_CHANGE_CATEGORY_HISTOGRAM_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCCH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define TCCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tcch_pkg.sv =====
// Types, constants and helpers of the tie change category histogram.
package tcch_pkg;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned CATS    = 16;
  localparam int unsigned CAT_W   = 4;
  localparam int unsigned KINDS   = 3;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned BINS    = KINDS * CATS;
  localparam int unsigned BIN_W   = KIND_W + CAT_W;
  localparam int unsigned COUNT_W = 10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_ADDED   = 2'd0,
    KIND_DROPPED = 2'd1,
    KIND_STABLE  = 2'd2
  } tie_kind_e;

  typedef enum logic {
    ST_COUNT = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  function automatic logic is_pos(input logic signed [VAL_W-1:0] v);
    return (v != '0) && !v[VAL_W-1];
  endfunction

endpackage

// ===== hdl/tcch_pair_if.sv =====
// Input channel: one ego-alter pair per word.
interface tcch_pair_if;
  logic                                 valid;
  logic                                 ready;
  logic        [tcch_pkg::IDX_W-1:0]    ego_index;
  logic        [tcch_pkg::IDX_W-1:0]    alter_index;
  logic signed [tcch_pkg::VAL_W-1:0]    edge_before;
  logic signed [tcch_pkg::VAL_W-1:0]    edge_after;
  logic signed [tcch_pkg::VAL_W-1:0]    ego_adopt_before;
  logic signed [tcch_pkg::VAL_W-1:0]    ego_adopt_after;
  logic signed [tcch_pkg::VAL_W-1:0]    alter_adopt_before;
  logic signed [tcch_pkg::VAL_W-1:0]    alter_adopt_after;
  logic                                 last_alter;

  modport source (
    output valid, ego_index, alter_index, edge_before, edge_after,
           ego_adopt_before, ego_adopt_after, alter_adopt_before,
           alter_adopt_after, last_alter,
    input  ready
  );
  modport sink (
    input  valid, ego_index, alter_index, edge_before, edge_after,
           ego_adopt_before, ego_adopt_after, alter_adopt_before,
           alter_adopt_after, last_alter,
    output ready
  );
endinterface

// ===== hdl/tcch_count_if.sv =====
// Output channel: one histogram count per word.
interface tcch_count_if;
  logic                             valid;
  logic                             ready;
  logic [tcch_pkg::IDX_W-1:0]       ego_out;
  logic [tcch_pkg::KIND_W-1:0]      tie_kind;
  logic [tcch_pkg::CAT_W-1:0]       category;
  logic [tcch_pkg::COUNT_W-1:0]     tie_count;
  logic                             last_count;

  modport source (
    output valid, ego_out, tie_kind, category, tie_count, last_count,
    input  ready
  );
  modport sink (
    input  valid, ego_out, tie_kind, category, tie_count, last_count,
    output ready
  );
endinterface

// ===== hdl/tcch_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcch_ram #(
  parameter int unsigned Width = tcch_pkg::COUNT_W,
  parameter int unsigned Depth = tcch_pkg::BINS,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tie_change_category_histogram.sv =====
// Top level: tie change category histogram over one ego row.
//
//  channel   dir  word                                        handshake
//  pair_i    in   ego/alter index, 2 weights, 4 adoptions, last  valid/ready
//  count_o   out  ego, tie kind, category, count, last         valid/ready
//
// Pairs are taken one per cycle while pair_i.ready is high; each reads its
// counter from the 48-entry RAM, and the next cycle increments and writes it
// back, forwarding from the write of the previous cycle. The pair marked last
// closes the row: input stalls while the 48 counts stream out, one per cycle
// when count_o is ready. Per-entry valid bits make reset and the clear after
// readout immediate. count_o back-pressure stalls the readout only.
module tie_change_category_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  tcch_pair_if.sink   pair_i,
  tcch_count_if.source count_o
);

  localparam int unsigned BinW = tcch_pkg::BIN_W;
  localparam logic [BinW-1:0] LastBin = BinW'(tcch_pkg::BINS - 1);

  tcch_pkg::state_e state_q, state_d;

  // Count stage.
  logic                          s1_v_q;
  logic                          s1_en_q;
  logic                          s1_last_q;
  logic [BinW-1:0]               s1_bin_q;
  logic [tcch_pkg::IDX_W-1:0]    s1_ego_q;

  // Last write, for forwarding.
  logic                          wb_v_q;
  logic [BinW-1:0]               wb_bin_q;
  logic [tcch_pkg::COUNT_W-1:0]  wb_val_q;

  logic [tcch_pkg::BINS-1:0]     valid_q, valid_d;
  logic [tcch_pkg::IDX_W-1:0]    row_ego_q;

  // Readout.
  logic [BinW-1:0]               iss_q, iss_d;
  logic                          iss_done_q, iss_done_d;
  logic                          pend_q, pend_d;
  logic [BinW-1:0]               pend_idx_q;

  logic                          out_v_q, out_v_d;
  logic [tcch_pkg::IDX_W-1:0]    out_ego_q;
  logic [tcch_pkg::KIND_W-1:0]   out_kind_q;
  logic [tcch_pkg::CAT_W-1:0]    out_cat_q;
  logic [tcch_pkg::COUNT_W-1:0]  out_cnt_q;
  logic                          out_last_q;

  logic                          accept;
  logic                          in_en;
  tcch_pkg::tie_kind_e           in_kind;
  logic [tcch_pkg::CAT_W-1:0]    in_cat;
  logic [BinW-1:0]               in_bin;

  logic                          ram_we, ram_re;
  logic [BinW-1:0]               ram_raddr;
  logic [tcch_pkg::COUNT_W-1:0]  ram_rdata, old_cnt, new_cnt, rd_cnt;
  logic                          xfer, issue, drain_end;

  assign pair_i.ready = (state_q == tcch_pkg::ST_COUNT) && !(s1_v_q && s1_last_q);
  assign accept       = pair_i.valid && pair_i.ready;

  // Category and kind of the incoming pair.
  always_comb begin
    in_cat = {tcch_pkg::is_pos(pair_i.alter_adopt_before),
              tcch_pkg::is_pos(pair_i.ego_adopt_before),
              tcch_pkg::is_pos(pair_i.ego_adopt_after),
              tcch_pkg::is_pos(pair_i.alter_adopt_after)};
    in_en  = pair_i.ego_index != pair_i.alter_index;
    if (pair_i.edge_after > pair_i.edge_before) begin
      in_kind = tcch_pkg::KIND_ADDED;
    end else if (pair_i.edge_after < pair_i.edge_before) begin
      in_kind = tcch_pkg::KIND_DROPPED;
    end else begin
      in_kind = tcch_pkg::KIND_STABLE;
      // unchanged zero weight counts nowhere
      if (pair_i.edge_after == '0) begin
        in_en = 1'b0;
      end
    end
    in_bin = {in_kind, in_cat};
  end

  // Read-modify-write of the counter.
  always_comb begin
    if (wb_v_q && (wb_bin_q == s1_bin_q)) begin
      old_cnt = wb_val_q;
    end else if (valid_q[s1_bin_q]) begin
      old_cnt = ram_rdata;
    end else begin
      old_cnt = '0;
    end
    new_cnt = (old_cnt == tcch_pkg::COUNT_MAX) ? old_cnt
                                               : old_cnt + tcch_pkg::COUNT_W'(1);
    ram_we  = s1_v_q && s1_en_q;
  end

  // Readout control.
  assign xfer      = pend_q && (!out_v_q || count_o.ready);
  assign issue     = (state_q == tcch_pkg::ST_DRAIN) && !iss_done_q && (!pend_q || xfer);
  assign drain_end = xfer && (pend_idx_q == LastBin);
  assign rd_cnt    = valid_q[pend_idx_q] ? ram_rdata : '0;
  assign ram_re    = accept || issue;
  assign ram_raddr = (state_q == tcch_pkg::ST_DRAIN) ? iss_q : in_bin;

  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    iss_done_d = iss_done_q;
    valid_d    = valid_q;
    pend_d     = pend_q;
    out_v_d    = out_v_q;
    if (ram_we) begin
      valid_d[s1_bin_q] = 1'b1;
    end
    if (issue) begin
      iss_d      = iss_q + BinW'(1);
      iss_done_d = iss_q == LastBin;
    end
    if (issue) begin
      pend_d = 1'b1;
    end else if (xfer) begin
      pend_d = 1'b0;
    end
    if (xfer) begin
      out_v_d = 1'b1;
    end else if (count_o.ready) begin
      out_v_d = 1'b0;
    end
    case (state_q)
      tcch_pkg::ST_COUNT: begin
        if (s1_v_q && s1_last_q) begin
          state_d = tcch_pkg::ST_DRAIN;
        end
      end
      tcch_pkg::ST_DRAIN: begin
        if (drain_end) begin
          state_d    = tcch_pkg::ST_COUNT;
          iss_d      = '0;
          iss_done_d = 1'b0;
          valid_d    = '0;
        end
      end
      default: begin
        state_d = tcch_pkg::ST_COUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcch_pkg::ST_COUNT;
      s1_v_q     <= 1'b0;
      wb_v_q     <= 1'b0;
      valid_q    <= '0;
      iss_q      <= '0;
      iss_done_q <= 1'b0;
      pend_q     <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      s1_v_q     <= accept;
      wb_v_q     <= ram_we;
      valid_q    <= valid_d;
      iss_q      <= iss_d;
      iss_done_q <= iss_done_d;
      pend_q     <= pend_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_en_q   <= in_en;
      s1_last_q <= pair_i.last_alter;
      s1_bin_q  <= in_bin;
      s1_ego_q  <= pair_i.ego_index;
    end
    if (ram_we) begin
      wb_bin_q <= s1_bin_q;
      wb_val_q <= new_cnt;
    end
    if (s1_v_q && s1_last_q) begin
      row_ego_q <= s1_ego_q;
    end
    if (issue) begin
      pend_idx_q <= iss_q;
    end
    if (xfer) begin
      out_ego_q  <= row_ego_q;
      out_kind_q <= pend_idx_q[BinW-1 -: tcch_pkg::KIND_W];
      out_cat_q  <= pend_idx_q[tcch_pkg::CAT_W-1:0];
      out_cnt_q  <= rd_cnt;
      out_last_q <= pend_idx_q == LastBin;
    end
  end

  tcch_ram #(
    .Width (tcch_pkg::COUNT_W),
    .Depth (tcch_pkg::BINS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_bin_q),
    .wdata_i (new_cnt),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_o.valid      = out_v_q;
  assign count_o.ego_out    = out_ego_q;
  assign count_o.tie_kind   = out_kind_q;
  assign count_o.category   = out_cat_q;
  assign count_o.tie_count  = out_cnt_q;
  assign count_o.last_count = out_last_q;

endmodule

// ===== hdl/tcch_checker.sv =====
// Port-level checks of the tie change histogram, bound to the top level.
`include "tie_change_category_histogram_defines.svh"

module tcch_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [tcch_pkg::IDX_W-1:0]      ego_out_i,
  input logic [tcch_pkg::KIND_W-1:0]     tie_kind_i,
  input logic [tcch_pkg::CAT_W-1:0]      category_i,
  input logic [tcch_pkg::COUNT_W-1:0]    tie_count_i,
  input logic                            last_count_i
);

  `TCCH_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i,
    "count word dropped while stalled")

  `TCCH_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i,
    $stable(tie_count_i) && $stable(category_i) && $stable(tie_kind_i) &&
    $stable(ego_out_i) && $stable(last_count_i),
    "count word changed while stalled")

  // input stays closed until the final count of the row is shown
  `TCCH_ASSERT_IMPL(a_drain_blocks_in, out_valid_i && !last_count_i, !in_ready_i,
    "pair taken during readout")

  `TCCH_ASSERT_IMPL(a_last_is_final_bin, out_valid_i && last_count_i,
    (tie_kind_i == tcch_pkg::KIND_STABLE) &&
    (category_i == tcch_pkg::CAT_W'(tcch_pkg::CATS - 1)),
    "last flag on a count other than the final bin")

endmodule

bind tie_change_category_histogram tcch_checker u_tcch_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (pair_i.ready),
  .out_valid_i  (count_o.valid),
  .out_ready_i  (count_o.ready),
  .ego_out_i    (count_o.ego_out),
  .tie_kind_i   (count_o.tie_kind),
  .category_i   (count_o.category),
  .tie_count_i  (count_o.tie_count),
  .last_count_i (count_o.last_count)
);
